@@ rtl/sps_pkg.sv @@
// shared types, constants and reset values for the servo pwm slew controller
package sps_pkg;

    localparam int ANGLE_BITS_DEF = 8;
    localparam int PULSE_BITS_DEF = 12;
    localparam int CNT_W          = 15;
    localparam int DATA_W         = 32;
    localparam int ADDR_W         = 5;
    localparam int REG_LSB        = 2;

    localparam int RST_ANGLE      = 90;
    localparam int RST_MIN_ANGLE  = 0;
    localparam int RST_MAX_ANGLE  = 180;
    localparam int RST_MIN_PULSE  = 544;
    localparam int RST_MAX_PULSE  = 2400;
    localparam int RST_PULSE      = 1472;
    localparam int RST_FRAME_US   = 20000;
    localparam int RST_STEP_US    = 20000;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_MOVE = 1'b1;

    typedef enum logic [2:0] {
        REG_ENABLED   = 3'd0,
        REG_MIN_ANGLE = 3'd1,
        REG_MAX_ANGLE = 3'd2,
        REG_MIN_PULSE = 3'd3,
        REG_MAX_PULSE = 3'd4,
        REG_FRAME_US  = 3'd5,
        REG_STEP_US   = 3'd6
    } t_sps_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIX,
        ST_RES
    } t_sps_state;

    typedef struct packed {
        logic accept;
        logic mul;
        logic div_step;
        logic fix;
        logic load_res;
    } t_sps_cmd;

    typedef struct packed {
        logic need_map;
        logic den_zero;
        logic div_last;
    } t_sps_stat;

endpackage

@@ rtl/sps_in_if.sv @@
// input channel: tick or move command
interface sps_in_if #(
    parameter int ANGLE_BITS = sps_pkg::ANGLE_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [ANGLE_BITS-1:0] goal_angle;
    logic                  immediate;

    modport source (output valid, output func, output goal_angle, output immediate,
                    input ready);
    modport sink (input valid, input func, input goal_angle, input immediate,
                  output ready);
endinterface

@@ rtl/sps_out_if.sv @@
// result channel: pwm level and servo status
interface sps_out_if #(
    parameter int ANGLE_BITS = sps_pkg::ANGLE_BITS_DEF,
    parameter int PULSE_BITS = sps_pkg::PULSE_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic                  pwm_level;
    logic [ANGLE_BITS-1:0] angle_now;
    logic [PULSE_BITS-1:0] pulse_now_us;
    logic                  moving;

    modport source (output valid, output pwm_level, output angle_now, output pulse_now_us,
                    output moving, input ready);
    modport sink (input valid, input pwm_level, input angle_now, input pulse_now_us,
                  input moving, output ready);
endinterface

@@ rtl/sps_ctrl.sv @@
// controller state machine: sequencing of transfers, mapping and serial divide
module sps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  logic              i_attach_set,
    input  sps_pkg::t_sps_stat i_stat,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output sps_pkg::t_sps_cmd  o_cmd
);

    sps_pkg::t_sps_state r_state, n_state;
    logic                r_with_res, n_with_res;
    logic                r_attach, n_attach;
    logic                r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sps_pkg::ST_IDLE;
            r_with_res  <= 1'b0;
            r_attach    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_with_res  <= n_with_res;
            r_attach    <= n_attach;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state    = r_state;
        n_with_res = r_with_res;
        n_attach   = r_attach | i_attach_set;
        case (r_state)
            sps_pkg::ST_IDLE: begin
                if (r_attach) begin
                    n_state    = sps_pkg::ST_MUL;
                    n_with_res = 1'b0;
                    n_attach   = i_attach_set;
                end else if (i_in_valid) begin
                    n_with_res = 1'b1;
                    n_state    = i_stat.need_map ? sps_pkg::ST_MUL : sps_pkg::ST_RES;
                end
            end
            sps_pkg::ST_MUL: begin
                n_state = i_stat.den_zero ? sps_pkg::ST_FIX : sps_pkg::ST_DIV;
            end
            sps_pkg::ST_DIV: begin
                if (i_stat.div_last) begin
                    n_state = sps_pkg::ST_FIX;
                end
            end
            sps_pkg::ST_FIX: begin
                n_state = r_with_res ? sps_pkg::ST_RES : sps_pkg::ST_IDLE;
            end
            sps_pkg::ST_RES: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = sps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sps_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            sps_pkg::ST_IDLE: begin
                o_in_ready   = !r_attach;
                o_cmd.accept = !r_attach && i_in_valid;
            end
            sps_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            sps_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            sps_pkg::ST_FIX: begin
                o_cmd.fix = 1'b1;
            end
            sps_pkg::ST_RES: begin
                o_cmd.load_res = !r_out_valid || i_out_ready;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_res) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/sps_dp.sv @@
// datapath: angle state, frame and step counters, width mapping with serial divider
module sps_dp #(
    parameter int ANGLE_BITS = sps_pkg::ANGLE_BITS_DEF,
    parameter int PULSE_BITS = sps_pkg::PULSE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  sps_pkg::t_sps_cmd        i_cmd,
    output sps_pkg::t_sps_stat       o_stat,
    input  logic                     i_enabled,
    input  logic [ANGLE_BITS-1:0]    i_min_angle,
    input  logic [ANGLE_BITS-1:0]    i_max_angle,
    input  logic [PULSE_BITS-1:0]    i_min_pulse,
    input  logic [PULSE_BITS-1:0]    i_max_pulse,
    input  logic [sps_pkg::CNT_W-1:0] i_frame_us,
    input  logic [sps_pkg::CNT_W-1:0] i_step_us,
    input  logic                     i_func,
    input  logic [ANGLE_BITS-1:0]    i_goal_angle,
    input  logic                     i_immediate,
    output logic                     o_pwm_level,
    output logic [ANGLE_BITS-1:0]    o_angle_now,
    output logic [PULSE_BITS-1:0]    o_pulse_now,
    output logic                     o_moving
);

    localparam int A      = ANGLE_BITS;
    localparam int P      = PULSE_BITS;
    localparam int CW     = sps_pkg::CNT_W;
    localparam int NUM_W  = A + P;
    localparam int W2     = A + P + 2;
    localparam int CMP_W  = (P > CW) ? P : CW;
    localparam int CNT_B  = $clog2(NUM_W);

    logic [A-1:0]   r_angle;
    logic [A-1:0]   r_goal;
    logic [P-1:0]   r_pulse;
    logic [CW-1:0]  r_frame;
    logic [CW-1:0]  r_step;

    logic           r_lvl_tick;
    logic           r_lvl_cmd;

    logic [NUM_W-1:0] r_num;
    logic [A-1:0]     r_den;
    logic [A-1:0]     r_rem;
    logic             r_neg;
    logic [CNT_B-1:0] r_cnt;
    logic [P-1:0]     r_lo_p;
    logic [P-1:0]     r_hi_p;

    logic           r_o_level;
    logic [A-1:0]   r_o_angle;
    logic [P-1:0]   r_o_pulse;
    logic           r_o_moving;

    logic [CW:0]    frame_next;
    logic [CW:0]    step_next;
    logic           frame_wrap;
    logic           step_fire;
    logic           level_now;
    logic           angle_ne;
    logic [A-1:0]   goal_clamp;
    logic [A-1:0]   a_clamp;

    logic signed [A:0]    diff_a;
    logic signed [A:0]    den_s;
    logic signed [P:0]    diff_p;
    logic signed [W2-1:0] prod;
    logic signed [W2-1:0] prod_abs;
    logic [A:0]           den_mag;

    logic [A:0]           rem_sh;
    logic [A:0]           rem_sub;
    logic                 rem_ge;

    logic signed [W2-1:0] q_s;
    logic signed [W2-1:0] lo_s;
    logic signed [W2-1:0] hi_s;
    logic signed [W2-1:0] w_raw;
    logic signed [W2-1:0] w_lo;
    logic signed [W2-1:0] w_fix;

    // counters and item decode
    always_comb begin
        frame_next = {1'b0, r_frame} + (CW+1)'(1);
        step_next  = {1'b0, r_step} + (CW+1)'(1);
        frame_wrap = frame_next >= {1'b0, i_frame_us};
        step_fire  = step_next >= {1'b0, i_step_us};
        level_now  = CMP_W'(r_frame) < CMP_W'(r_pulse);
        angle_ne   = r_angle != r_goal;
        goal_clamp = (i_goal_angle > i_max_angle) ? i_max_angle : i_goal_angle;
        a_clamp    = (r_angle > i_max_angle) ? i_max_angle : r_angle;
    end

    // linear map: product and divisor magnitude
    always_comb begin
        diff_a   = $signed({1'b0, a_clamp}) - $signed({1'b0, i_min_angle});
        den_s    = $signed({1'b0, i_max_angle}) - $signed({1'b0, i_min_angle});
        diff_p   = $signed({1'b0, i_max_pulse}) - $signed({1'b0, i_min_pulse});
        prod     = W2'(diff_a) * W2'(diff_p);
        prod_abs = prod[W2-1] ? -prod : prod;
        den_mag  = den_s[A] ? (A+1)'(-den_s) : (A+1)'(den_s);
    end

    // restoring divide, one quotient bit per cycle
    always_comb begin
        rem_sh  = {r_rem, r_num[NUM_W-1]};
        rem_ge  = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
    end

    // sign, offset and clamp
    always_comb begin
        q_s   = $signed({2'b00, r_num});
        lo_s  = $signed({{(A+2){1'b0}}, r_lo_p});
        hi_s  = $signed({{(A+2){1'b0}}, r_hi_p});
        w_raw = (r_neg ? -q_s : q_s) + lo_s;
        w_lo  = (w_raw < lo_s) ? lo_s : w_raw;
        w_fix = (w_lo > hi_s) ? hi_s : w_lo;
    end

    always_comb begin
        o_stat.need_map = i_enabled &&
            ((i_func == sps_pkg::FUNC_MOVE) ? i_immediate : (step_fire && angle_ne));
        o_stat.den_zero = den_s == '0;
        o_stat.div_last = r_cnt == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= A'(sps_pkg::RST_ANGLE);
            r_goal  <= A'(sps_pkg::RST_ANGLE);
            r_pulse <= P'(sps_pkg::RST_PULSE);
            r_frame <= '0;
            r_step  <= '0;
        end else begin
            if (i_cmd.accept && i_enabled) begin
                if (i_func == sps_pkg::FUNC_TICK) begin
                    r_frame <= frame_wrap ? '0 : frame_next[CW-1:0];
                    r_step  <= step_fire ? '0 : step_next[CW-1:0];
                    if (step_fire && angle_ne) begin
                        r_angle <= (r_angle < r_goal) ? r_angle + A'(1) : r_angle - A'(1);
                    end
                end else begin
                    r_goal <= goal_clamp;
                    if (i_immediate) begin
                        r_angle <= goal_clamp;
                    end
                end
            end
            if (i_cmd.mul) begin
                r_angle <= a_clamp;
            end
            if (i_cmd.fix) begin
                r_pulse <= w_fix[P-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_lvl_tick <= i_enabled && (i_func == sps_pkg::FUNC_TICK) && level_now;
            r_lvl_cmd  <= i_enabled && (i_func == sps_pkg::FUNC_MOVE);
        end
        if (i_cmd.mul) begin
            r_num  <= o_stat.den_zero ? '0 : prod_abs[NUM_W-1:0];
            r_den  <= den_mag[A-1:0];
            r_rem  <= '0;
            r_neg  <= prod[W2-1] ^ den_s[A];
            r_cnt  <= CNT_B'(NUM_W - 1);
            r_lo_p <= i_min_pulse;
            r_hi_p <= i_max_pulse;
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_sub[A-1:0] : rem_sh[A-1:0];
            r_num <= {r_num[NUM_W-2:0], rem_ge};
            r_cnt <= r_cnt - CNT_B'(1);
        end
        if (i_cmd.load_res) begin
            r_o_level  <= r_lvl_tick || (r_lvl_cmd && level_now);
            r_o_angle  <= r_angle;
            r_o_pulse  <= r_pulse;
            r_o_moving <= angle_ne;
        end
    end

    assign o_pwm_level = r_o_level;
    assign o_angle_now = r_o_angle;
    assign o_pulse_now = r_o_pulse;
    assign o_moving    = r_o_moving;

endmodule

@@ rtl/servo_pwm_slew_controller_unit.sv @@
// top level: register file, controller and datapath of the servo pwm slew controller
// Each transfer on i_cmd is a one-microsecond tick or a move command and yields one
// transfer on o_res. An item that leaves the angle alone goes from ST_IDLE straight to
// ST_RES; one that remaps the angle (slew step or immediate move) first passes ST_MUL,
// ST_DIV (skipped when the angle range is zero) and ST_FIX, where the serial divider of
// the angle-to-width map produces one quotient bit per cycle. Setting enabled from 0 to 1
// remaps the current angle and holds off i_cmd until that remap is done. A new item is
// taken while the previous result still waits on o_res.
module servo_pwm_slew_controller_unit #(
    parameter int ANGLE_BITS = sps_pkg::ANGLE_BITS_DEF,
    parameter int PULSE_BITS = sps_pkg::PULSE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    sps_in_if.sink                      i_cmd,
    sps_out_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sps_pkg::ADDR_W-1:0]  paddr,
    input  logic [sps_pkg::DATA_W-1:0]  pwdata,
    output logic [sps_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int CW = sps_pkg::CNT_W;
    localparam int DW = sps_pkg::DATA_W;

    logic                  r_enabled;
    logic [ANGLE_BITS-1:0] r_min_angle;
    logic [ANGLE_BITS-1:0] r_max_angle;
    logic [PULSE_BITS-1:0] r_min_pulse;
    logic [PULSE_BITS-1:0] r_max_pulse;
    logic [CW-1:0]         r_frame_us;
    logic [CW-1:0]         r_step_us;

    sps_pkg::t_sps_reg     reg_sel;
    logic                  wr_en;
    logic                  attach_set;
    sps_pkg::t_sps_cmd     cmd;
    sps_pkg::t_sps_stat    stat;

    assign reg_sel    = sps_pkg::t_sps_reg'(paddr[sps_pkg::ADDR_W-1:sps_pkg::REG_LSB]);
    assign wr_en      = psel && penable && pwrite;
    assign attach_set = wr_en && (reg_sel == sps_pkg::REG_ENABLED) && pwdata[0] && !r_enabled;
    assign pready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b0;
            r_min_angle <= ANGLE_BITS'(sps_pkg::RST_MIN_ANGLE);
            r_max_angle <= ANGLE_BITS'(sps_pkg::RST_MAX_ANGLE);
            r_min_pulse <= PULSE_BITS'(sps_pkg::RST_MIN_PULSE);
            r_max_pulse <= PULSE_BITS'(sps_pkg::RST_MAX_PULSE);
            r_frame_us  <= CW'(sps_pkg::RST_FRAME_US);
            r_step_us   <= CW'(sps_pkg::RST_STEP_US);
        end else if (wr_en) begin
            case (reg_sel)
                sps_pkg::REG_ENABLED:   r_enabled   <= pwdata[0];
                sps_pkg::REG_MIN_ANGLE: r_min_angle <= pwdata[ANGLE_BITS-1:0];
                sps_pkg::REG_MAX_ANGLE: r_max_angle <= pwdata[ANGLE_BITS-1:0];
                sps_pkg::REG_MIN_PULSE: r_min_pulse <= pwdata[PULSE_BITS-1:0];
                sps_pkg::REG_MAX_PULSE: r_max_pulse <= pwdata[PULSE_BITS-1:0];
                sps_pkg::REG_FRAME_US:  r_frame_us  <= pwdata[CW-1:0];
                sps_pkg::REG_STEP_US:   r_step_us   <= pwdata[CW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            sps_pkg::REG_ENABLED:   prdata = DW'(r_enabled);
            sps_pkg::REG_MIN_ANGLE: prdata = DW'(r_min_angle);
            sps_pkg::REG_MAX_ANGLE: prdata = DW'(r_max_angle);
            sps_pkg::REG_MIN_PULSE: prdata = DW'(r_min_pulse);
            sps_pkg::REG_MAX_PULSE: prdata = DW'(r_max_pulse);
            sps_pkg::REG_FRAME_US:  prdata = DW'(r_frame_us);
            sps_pkg::REG_STEP_US:   prdata = DW'(r_step_us);
            default:                prdata = '0;
        endcase
    end

    sps_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_cmd.valid),
        .i_out_ready  (o_res.ready),
        .i_attach_set (attach_set),
        .i_stat       (stat),
        .o_in_ready   (i_cmd.ready),
        .o_out_valid  (o_res.valid),
        .o_cmd        (cmd)
    );

    sps_dp #(
        .ANGLE_BITS (ANGLE_BITS),
        .PULSE_BITS (PULSE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_enabled    (r_enabled),
        .i_min_angle  (r_min_angle),
        .i_max_angle  (r_max_angle),
        .i_min_pulse  (r_min_pulse),
        .i_max_pulse  (r_max_pulse),
        .i_frame_us   (r_frame_us),
        .i_step_us    (r_step_us),
        .i_func       (i_cmd.func),
        .i_goal_angle (i_cmd.goal_angle),
        .i_immediate  (i_cmd.immediate),
        .o_pwm_level  (o_res.pwm_level),
        .o_angle_now  (o_res.angle_now),
        .o_pulse_now  (o_res.pulse_now_us),
        .o_moving     (o_res.moving)
    );

endmodule
